// ===== hw/rtl/dshot_frame_encoder_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the DShot frame encoder checker.
// Both macros expect clk and rst_n to be visible where they are used.
// ---------------------------------------------------------------------------
`ifndef DSHOT_FRAME_ENCODER_TOP_DEFINES_SVH
`define DSHOT_FRAME_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DFE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dfe_pkg.sv =====
// ---------------------------------------------------------------------------
// dfe_pkg
// Types, constants and timing tables for the DShot frame encoder.
// ---------------------------------------------------------------------------
package dfe_pkg;

    // Frame geometry.
    localparam int FRAME_BITS = 16;
    localparam int CMD_W      = 11;
    localparam int CNT_W      = $clog2(FRAME_BITS);
    localparam int TIME_W     = 9;

    // Value limits for the two request kinds.
    localparam logic signed [15:0] RAW_MAX    = 16'sd2047;
    localparam logic signed [15:0] THR_MAX    = 16'sd1999;
    localparam logic [CMD_W-1:0]   THR_OFFSET = 11'd48;

    // Speed register reset value (DSHOT150).
    localparam logic [1:0] SPEED_RESET = 2'd3;

    typedef enum logic
    {
        OP_RAW      = 1'b0,
        OP_THROTTLE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        SPEED_1200 = 2'd0,
        SPEED_600  = 2'd1,
        SPEED_300  = 2'd2,
        SPEED_150  = 2'd3
    } speed_t;

    typedef logic [FRAME_BITS-1:0] frame_t;

    // Head of the frame queue as seen by the serialiser.
    typedef struct packed
    {
        logic   valid;
        frame_t frame;
    } q_head_t;

    // One output word, packed with the bit value in the lowest position.
    typedef struct packed
    {
        logic [TIME_W-1:0] low_time;
        logic [TIME_W-1:0] high_time;
        logic              bit_value;
    } out_item_t;

    // Bit period in 10 ns units.
    function automatic logic [9:0] period_f(input speed_t mode);
        logic [9:0] p;
        unique case (mode)
            SPEED_1200: p = 10'd83;
            SPEED_600:  p = 10'd167;
            SPEED_300:  p = 10'd333;
            SPEED_150:  p = 10'd667;
            default:    p = 10'd667;
        endcase
        return p;
    endfunction

    // Pulse high time for a one or a zero bit.
    function automatic logic [TIME_W-1:0] high_time_f(input speed_t mode, input logic b);
        logic [TIME_W-1:0] h;
        unique case (mode)
            SPEED_1200: h = b ? 9'd63  : 9'd31;
            SPEED_600:  h = b ? 9'd125 : 9'd63;
            SPEED_300:  h = b ? 9'd250 : 9'd125;
            SPEED_150:  h = b ? 9'd500 : 9'd250;
            default:    h = b ? 9'd500 : 9'd250;
        endcase
        return h;
    endfunction

endpackage

// ===== hw/rtl/dshot_frame_encoder_top.sv =====
// ---------------------------------------------------------------------------
// dshot_frame_encoder_top
// DShot frame encoder: request in, sixteen timed frame bits out.
// ---------------------------------------------------------------------------
// Each accepted request word gives sixteen output words, one per frame bit,
// MSB first, with tlast on the sixteenth. The serialiser emits one bit per
// cycle while the receiver is ready, and back-to-back requests stream with
// no gap between frames; a request passes through the frame queue, the
// shift register and the output register before its first bit appears.
// The input side keeps accepting while the frame queue (FIFO_DEPTH frames)
// has room. speed_mode selects DSHOT1200/600/300/150 timing and should only
// be written while no frame is in flight.
// ---------------------------------------------------------------------------
module dshot_frame_encoder_top
    import dfe_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Speed register write.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,     // speed_mode
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] value (signed)
    input  logic        s_axis_tuser,    // [0] op
    // Bit stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [0] bit_value, [9:1] high_time,
                                         // [18:10] low_time, [23:19] zero
    output logic        m_axis_tlast     // last_bit
);

    logic [1:0] speed_reg;
    logic       fifo_full;
    logic       fifo_push;
    logic       fifo_pop;
    frame_t     front_frame;
    q_head_t    fifo_head;
    out_item_t  out_item;

    // Speed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= SPEED_RESET;
        else if (cfg_wr_en)
            speed_reg <= cfg_wr_data;
    end

    assign s_axis_tready = !fifo_full;
    assign fifo_push     = s_axis_tvalid && !fifo_full;

    // Front end: clamp and frame build.
    dfe_front u_front
    (
        .op    (s_axis_tuser),
        .value (s_axis_tdata),
        .frame (front_frame)
    );

    // Frame queue.
    dfe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (front_frame),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .head      (fifo_head)
    );

    // Bit serialiser.
    dfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .speed     (speed_t'(speed_reg)),
        .head      (fifo_head),
        .pop       (fifo_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_item};

endmodule

// ===== hw/rtl/dfe_front.sv =====
// ---------------------------------------------------------------------------
// dfe_front
// Clamps the request value for its kind and builds the 16-bit frame with
// its telemetry bit and nibble checksum.
// ---------------------------------------------------------------------------
module dfe_front
    import dfe_pkg::*;
(
    input  logic               op,
    input  logic signed [15:0] value,
    output frame_t             frame
);

    logic [CMD_W-1:0] cmd;
    logic [11:0]      word12;
    logic [3:0]       crc;

    // Clamp to the range of the request kind; throttle gets its offset.
    always_comb
    begin
        if (op == OP_THROTTLE)
        begin
            if (value < 0)
                cmd = THR_OFFSET;
            else if (value > THR_MAX)
                cmd = THR_MAX[CMD_W-1:0] + THR_OFFSET;
            else
                cmd = value[CMD_W-1:0] + THR_OFFSET;
        end
        else
        begin
            if (value < 0)
                cmd = '0;
            else if (value > RAW_MAX)
                cmd = RAW_MAX[CMD_W-1:0];
            else
                cmd = value[CMD_W-1:0];
        end
    end

    // Telemetry request is never set; the checksum folds three nibbles.
    assign word12 = {cmd, 1'b0};
    assign crc    = word12[3:0] ^ word12[7:4] ^ word12[11:8];
    assign frame  = {word12, crc};

endmodule

// ===== hw/rtl/dfe_fifo.sv =====
// ---------------------------------------------------------------------------
// dfe_fifo
// Short frame queue between the front end and the bit serialiser.
// ---------------------------------------------------------------------------
module dfe_fifo
    import dfe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  frame_t  push_data,
    output logic    full,
    input  logic    pop,
    output q_head_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_t        mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.frame = mem_reg[rd_ptr_reg];

    // Pointer and count update; pointers wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/dfe_back.sv =====
// ---------------------------------------------------------------------------
// dfe_back
// Bit serialiser: shifts a frame out MSB first, one word per cycle while the
// output is not stalled, with the pulse timing for the current speed, through an output register.
// ---------------------------------------------------------------------------
module dfe_back
    import dfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  speed_t    speed,
    input  q_head_t   head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item,
    output logic      out_last
);

    localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(FRAME_BITS - 1);

    frame_t            shift_reg, shift_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              valid_reg, valid_next;
    out_item_t         item_reg, item_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic              emit;
    logic              cur_bit;
    logic [9:0]        low_wide;

    assign out_free = !valid_reg || out_ready;
    assign emit     = busy_reg && out_free;
    assign cur_bit  = shift_reg[FRAME_BITS-1];
    assign low_wide = period_f(speed) - {1'b0, high_time_f(speed, cur_bit)};

    // Emit the current bit, and load the next frame when the last bit goes
    // out or when the serialiser is idle.
    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        valid_next = out_free ? busy_reg : valid_reg;
        item_next  = item_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (emit)
        begin
            item_next.bit_value = cur_bit;
            item_next.high_time = high_time_f(speed, cur_bit);
            item_next.low_time  = low_wide[TIME_W-1:0];
            last_next           = (cnt_reg == BIT_LAST);
            shift_next          = {shift_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next            = cnt_reg + 1'b1;
            if (cnt_reg == BIT_LAST)
                busy_next = 1'b0;
        end
        if ((!busy_reg || (emit && cnt_reg == BIT_LAST)) && head.valid)
        begin
            pop        = 1'b1;
            shift_next = head.frame;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        item_reg  <= item_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_last  = last_reg;

endmodule

// ===== hw/rtl/dfe_chk.sv =====
// ---------------------------------------------------------------------------
// dfe_chk
// Port-level checks on the output bit stream of the DShot frame encoder.
// ---------------------------------------------------------------------------
`include "dshot_frame_encoder_top_defines.svh"

module dfe_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic [9:0] bit_period;

    assign bit_period = 10'(m_axis_tdata[9:1]) + 10'(m_axis_tdata[18:10]);

    // A stalled word holds.
    `DFE_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

    // Padding bits stay clear.
    `DFE_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:19] == 5'd0, "tdata padding not zero")

    // A one bit is the long pulse, a zero bit the short one.
    `DFE_ASSERT_IMPL(a_bit_shape, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[9:1] > m_axis_tdata[18:10]), "pulse shape does not match bit value")

    // High and low time add up to one of the four bit periods.
    `DFE_ASSERT_IMPL(a_period, m_axis_tvalid, bit_period == 10'd83 || bit_period == 10'd167 || bit_period == 10'd333 || bit_period == 10'd667, "bit period is not a DShot period")

endmodule

bind dshot_frame_encoder_top dfe_chk u_dfe_chk (.*);

// ===== tb/dshot_frame_encoder_checker.sv =====
// ---------------------------------------------------------------------------
// dshot_bit_checker
// Watches the request, bit and speed-register ports of the DShot frame
// encoder. It predicts the sixteen timed frame bits of every accepted
// request and compares each accepted bit word with the oldest prediction.
// ---------------------------------------------------------------------------
module dshot_bit_checker
    import dfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_bits
);

    // One predicted frame bit with its pulse timing.
    typedef struct packed
    {
        logic              bit_value;
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] low_time;
        logic              last_bit;
    } frame_bit_t;

    frame_bit_t expected_bits[$];
    speed_t     speed_now;
    int         errors;

    // Clamp the request, add the telemetry bit and append the nibble checksum.
    function automatic frame_t encode_frame(input op_t op, input logic signed [15:0] value);
        logic [CMD_W-1:0] cmd;
        logic [11:0]      word12;
        logic [3:0]       crc;
        if (op == OP_THROTTLE)
        begin
            if (value > THR_MAX)
                cmd = THR_MAX[CMD_W-1:0] + THR_OFFSET;
            else if (value < 0)
                cmd = THR_OFFSET;
            else
                cmd = value[CMD_W-1:0] + THR_OFFSET;
        end
        else
        begin
            if (value > RAW_MAX)
                cmd = RAW_MAX[CMD_W-1:0];
            else if (value < 0)
                cmd = '0;
            else
                cmd = value[CMD_W-1:0];
        end
        word12 = {cmd, 1'b0};
        crc    = word12[3:0] ^ word12[7:4] ^ word12[11:8];
        return {word12, crc};
    endfunction

    // Full bit period for each speed, in 10 ns units.
    function automatic logic [9:0] bit_period(input speed_t s);
        case (s)
            SPEED_1200: return 10'd83;
            SPEED_600:  return 10'd167;
            SPEED_300:  return 10'd333;
            default:    return 10'd667;
        endcase
    endfunction

    // Pulse high time: roughly three quarters of the period for a one,
    // three eighths for a zero.
    function automatic logic [TIME_W-1:0] pulse_high(input speed_t s, input logic b);
        case (s)
            SPEED_1200: return b ? 9'd63  : 9'd31;
            SPEED_600:  return b ? 9'd125 : 9'd63;
            SPEED_300:  return b ? 9'd250 : 9'd125;
            default:    return b ? 9'd500 : 9'd250;
        endcase
    endfunction

    // Track the speed register, check bit words and queue new predictions.
    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_bit_t want;
        frame_bit_t got;
        frame_bit_t next_bit;
        frame_t     frame;
        logic [9:0] period;
        if (!rst_n)
        begin
            expected_bits.delete();
            speed_now    = speed_t'(SPEED_RESET);
            errors       = 0;
            fail_count   <= 0;
            pending_bits <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                speed_now = speed_t'(cfg_wr_data);

            // Outgoing bit word against the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.bit_value = m_axis_tdata[0];
                got.high_time = m_axis_tdata[9:1];
                got.low_time  = m_axis_tdata[18:10];
                got.last_bit  = m_axis_tlast;
                if (expected_bits.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected bit word: bit %0b high %0d low %0d last %0b",
                             $time, got.bit_value, got.high_time, got.low_time,
                             got.last_bit);
                end
                else
                begin
                    want = expected_bits.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display({"%0t: bit word mismatch: expected bit %0b high %0d ",
                                  "low %0d last %0b, got bit %0b high %0d low %0d last %0b"},
                                 $time, want.bit_value, want.high_time, want.low_time,
                                 want.last_bit, got.bit_value, got.high_time,
                                 got.low_time, got.last_bit);
                    end
                end
            end

            // A new request gives sixteen bits, MSB first.
            if (s_axis_tvalid && s_axis_tready)
            begin
                frame  = encode_frame(op_t'(s_axis_tuser), s_axis_tdata);
                period = bit_period(speed_now);
                for (int k = FRAME_BITS - 1; k >= 0; k--)
                begin
                    next_bit.bit_value = frame[k];
                    next_bit.high_time = pulse_high(speed_now, frame[k]);
                    next_bit.low_time  = TIME_W'(period - 10'(next_bit.high_time));
                    next_bit.last_bit  = (k == 0);
                    expected_bits.push_back(next_bit);
                end
            end

            fail_count   <= errors;
            pending_bits <= expected_bits.size();
        end
    end

endmodule

// ===== tb/tb_dshot_frame_encoder_top.sv =====
// ---------------------------------------------------------------------------
// tb_dshot_frame_encoder_top
// Stimulus and verdict for the DShot frame encoder. A directed set of raw
// and throttle requests at the field limits is followed by random requests
// over every speed setting, with phases of random sender gaps and receiver
// stalls, one long receiver hold-off and full drains between phases. The
// checker beside the block predicts and compares every bit word.
// ---------------------------------------------------------------------------
module tb_dshot_frame_encoder_top;
    import dfe_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_WORDS  = 110;
    localparam int SETTLE_TICKS = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    int fail_count;
    int pending_bits;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    bit hold_req;

    dshot_frame_encoder_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    dshot_bit_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_bits  (pending_bits)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin : receiver
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request word, with a random gap first, and wait for acceptance.
    task automatic send_request(input op_t op, input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted bit has been received.
    task automatic drain_bits();
        s_axis_tvalid = 1'b0;
        while (pending_bits != 0)
            @(negedge clk);
    endtask

    // Change the bit timing once the encoder is idle.
    task automatic write_speed(input speed_t s);
        drain_bits();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = s;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Mostly in-range values, some near the clamp limits, some anywhere.
    function automatic logic [15:0] random_value(input op_t op);
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
            return (op == OP_THROTTLE) ? 16'($urandom_range(1999)) : 16'($urandom_range(2047));
        else if (pick < 80)
            return 16'($urandom_range(2060, 1985));
        else if (pick < 88)
            return 16'(-$signed($urandom_range(40)));
        else
            return 16'($urandom);
    endfunction

    // Main stimulus.
    initial
    begin : stimulus
        op_t         op;
        logic [15:0] directed_raw [10];
        logic [15:0] directed_thr [8];
        speed_t      phase_speed  [8];
        int          phase_send   [4];
        int          phase_recv   [4];

        directed_raw = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0400,
                         16'd2047, 16'd2048, 16'h7FFF, 16'h0555, 16'h02AA};
        directed_thr = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001,
                         16'd1999, 16'd2000, 16'h7FFF, 16'd1000};
        phase_speed  = '{SPEED_1200, SPEED_150, SPEED_600, SPEED_300,
                         SPEED_150, SPEED_1200, SPEED_300, SPEED_600};
        phase_send   = '{0, 47, 0, 33};
        phase_recv   = '{0, 0, 47, 33};

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = SPEED_RESET;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_RAW;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Field limits and both clamp directions at the reset speed.
        foreach (directed_raw[i])
            send_request(OP_RAW, directed_raw[i]);
        foreach (directed_thr[i])
            send_request(OP_THROTTLE, directed_thr[i]);

        // Random phases, each with two speed settings.
        for (int p = 0; p < 4; p++)
        begin
            write_speed(phase_speed[2 * p]);
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == PHASE_WORDS / 2)
                    write_speed(phase_speed[2 * p + 1]);
                // A long receiver hold-off fills the frame queue.
                if (p == 0 && n == 20)
                    hold_req = 1'b1;
                op = op_t'($urandom_range(1));
                send_request(op, random_value(op));
            end
            drain_bits();
        end

        // Wait for the last bits and a quiet tail before the verdict.
        drain_bits();
        repeat (SETTLE_TICKS) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dfe_pkg.sv
hw/rtl/dfe_front.sv
hw/rtl/dfe_fifo.sv
hw/rtl/dfe_back.sv
hw/rtl/dshot_frame_encoder_top.sv
hw/rtl/dfe_chk.sv
tb/dshot_frame_encoder_checker.sv
tb/tb_dshot_frame_encoder_top.sv
